// File: sv/cmdc_pkg.sv
`timescale 1ns / 1ps

package cmdc_pkg;

  localparam int DIGIT_COUNT        = 4;
  localparam int DIGIT_IDX_W        = 2;
  localparam int DEFAULT_COUNT_BITS = 16;
  localparam int RAW_W              = 16;
  localparam int PERIOD_W           = 8;
  localparam int OFFSET_W           = 8;
  localparam int SCALE_W            = 14;
  localparam int CFG_DATA_W         = 14;
  localparam int CFG_IDX_W          = 2;
  localparam int CODE_W             = 4;
  localparam int BYTE_W             = 8;

  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 8'd48;
  localparam logic [OFFSET_W-1:0] COUNT_OFFSET_RST  = 8'd3;
  localparam logic [SCALE_W-1:0]  FULL_SCALE_RST    = 14'd2000;
  localparam logic [SCALE_W-1:0]  MAX_SCALE         = 14'd10000;

  localparam logic [CODE_W-1:0] BLANK_CODE = 4'd10;
  localparam logic [CODE_W-1:0] ONE_CODE   = 4'd1;
  localparam logic [BYTE_W-1:0] NO_STROBE  = 8'hff;
  localparam logic [BYTE_W-1:0] NO_SEGS    = 8'h00;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_COUNT_OFFSET  = 2'd1,
    CFG_FULL_SCALE    = 2'd2
  } cmdc_cfg_idx_t;

  // one classified transaction on its way from front to back
  typedef struct packed {
    logic                                is_tick;
    logic [DIGIT_IDX_W-1:0]              pos;
    logic                                charge_on;
    logic [DIGIT_COUNT-1:0][CODE_W-1:0]  digits;
  } cmdc_item_t;

  function automatic logic [BYTE_W-1:0] strobe_of(input logic [DIGIT_IDX_W-1:0] pos);
    logic [BYTE_W-1:0] s;
    case (pos)
      2'd0:    s = 8'hbf;
      2'd1:    s = 8'hdf;
      2'd2:    s = 8'hef;
      2'd3:    s = 8'hf7;
      default: s = 8'hbf;
    endcase
    return s;
  endfunction

  function automatic logic [BYTE_W-1:0] font_of(input logic [CODE_W-1:0] code);
    logic [BYTE_W-1:0] f;
    case (code)
      4'd0:    f = 8'hfe;
      4'd1:    f = 8'h70;
      4'd2:    f = 8'hed;
      4'd3:    f = 8'hf9;
      4'd4:    f = 8'h73;
      4'd5:    f = 8'hdb;
      4'd6:    f = 8'hdf;
      4'd7:    f = 8'hf0;
      4'd8:    f = 8'hff;
      4'd9:    f = 8'hfb;
      default: f = 8'h40;
    endcase
    return f;
  endfunction

endpackage

// File: sv/cmdc_front.sv
`timescale 1ns / 1ps

module cmdc_front import cmdc_pkg::*; #(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [RAW_W-1:0]      in_charge_count,
  input  logic                  q_full,
  output logic                  q_push,
  output cmdc_item_t            q_item
);

  localparam int CMP_W = (COUNT_BITS > SCALE_W) ? COUNT_BITS : SCALE_W;
  localparam int HUND_W = 7;
  localparam int PROD_W = SCALE_W + 13;

  typedef struct packed {
    logic                   is_tick;
    logic [DIGIT_IDX_W-1:0] pos;
    logic                   charge_on;
    logic                   over;
    logic [SCALE_W-1:0]     val;
  } cmdc_s1_t;

  typedef struct packed {
    logic                   is_tick;
    logic [DIGIT_IDX_W-1:0] pos;
    logic                   charge_on;
    logic                   over;
    logic [SCALE_W-1:0]     val;
    logic [HUND_W-1:0]      hund;
  } cmdc_s2_t;

  typedef struct packed {
    logic                   is_tick;
    logic [DIGIT_IDX_W-1:0] pos;
    logic                   charge_on;
    logic                   over;
    logic [HUND_W-1:0]      hund;
    logic [HUND_W-1:0]      rem;
  } cmdc_s3_t;

  // split a value below 100 into tens and units
  function automatic logic [2*CODE_W-1:0] split2(input logic [HUND_W-1:0] x);
    logic [14:0]       p;
    logic [CODE_W-1:0] hi;
    logic [CODE_W-1:0] lo;
    p  = 15'(x) * 15'd205;
    hi = CODE_W'(p >> 11);
    lo = CODE_W'(x - HUND_W'(hi) * HUND_W'(10));
    return {hi, lo};
  endfunction

  logic [PERIOD_W-1:0] period_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [SCALE_W-1:0]  scale_r;

  logic [DIGIT_IDX_W-1:0] ptr_r, ptr_nxt;
  logic [PERIOD_W-1:0]    tick_cnt_r, tick_cnt_nxt;
  logic                   charging_r, charging_nxt;

  logic     s1_v_r, s2_v_r, s3_v_r;
  cmdc_s1_t s1_r, s1_nxt;
  cmdc_s2_t s2_r, s2_nxt;
  cmdc_s3_t s3_r, s3_nxt;

  logic                  adv;
  logic                  accept;
  logic [COUNT_BITS-1:0] raw, cap;
  logic [SCALE_W-1:0]    limit;
  logic [PERIOD_W-1:0]   cnt_inc;
  logic [PROD_W-1:0]     prod;
  logic [2*CODE_W-1:0]   hi_pair, lo_pair;

  assign adv      = !q_full;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= SAMPLE_PERIOD_RST;
      offset_r <= COUNT_OFFSET_RST;
      scale_r  <= FULL_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_PERIOD: period_r <= PERIOD_W'(cfg_wdata);
        CFG_COUNT_OFFSET:  offset_r <= OFFSET_W'(cfg_wdata);
        CFG_FULL_SCALE:    scale_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // tick sequencing and charge control
  always_comb begin
    cnt_inc      = tick_cnt_r + 1'b1;
    ptr_nxt      = ptr_r;
    tick_cnt_nxt = tick_cnt_r;
    charging_nxt = charging_r;
    if (accept) begin
      if (!in_kind) begin
        ptr_nxt      = ptr_r + 1'b1;
        tick_cnt_nxt = cnt_inc;
        if (cnt_inc == period_r) begin
          tick_cnt_nxt = '0;
          charging_nxt = 1'b1;
        end
      end else begin
        charging_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      tick_cnt_r <= '0;
      charging_r <= 1'b0;
    end else begin
      ptr_r      <= ptr_nxt;
      tick_cnt_r <= tick_cnt_nxt;
      charging_r <= charging_nxt;
    end
  end

  // correct the count and classify against full scale
  always_comb begin
    raw   = COUNT_BITS'(in_charge_count);
    cap   = raw - COUNT_BITS'(offset_r);
    limit = (scale_r > MAX_SCALE) ? MAX_SCALE : scale_r;
    s1_nxt.is_tick   = !in_kind;
    s1_nxt.pos       = ptr_r;
    s1_nxt.charge_on = charging_nxt;
    s1_nxt.over      = CMP_W'(cap) >= CMP_W'(limit);
    s1_nxt.val       = SCALE_W'(cap);
  end

  // hundreds by reciprocal multiply, exact below 10000
  always_comb begin
    prod           = PROD_W'(s1_r.val) * PROD_W'(13'd5243);
    s2_nxt.is_tick   = s1_r.is_tick;
    s2_nxt.pos       = s1_r.pos;
    s2_nxt.charge_on = s1_r.charge_on;
    s2_nxt.over      = s1_r.over;
    s2_nxt.val       = s1_r.val;
    s2_nxt.hund      = HUND_W'(prod >> 19);
  end

  always_comb begin
    s3_nxt.is_tick   = s2_r.is_tick;
    s3_nxt.pos       = s2_r.pos;
    s3_nxt.charge_on = s2_r.charge_on;
    s3_nxt.over      = s2_r.over;
    s3_nxt.hund      = s2_r.hund;
    s3_nxt.rem       = HUND_W'(s2_r.val - SCALE_W'(s2_r.hund) * SCALE_W'(100));
  end

  always_comb begin
    hi_pair          = split2(s3_r.hund);
    lo_pair          = split2(s3_r.rem);
    q_item.is_tick   = s3_r.is_tick;
    q_item.pos       = s3_r.pos;
    q_item.charge_on = s3_r.charge_on;
    if (s3_r.over) begin
      q_item.digits[0] = ONE_CODE;
      q_item.digits[1] = BLANK_CODE;
      q_item.digits[2] = BLANK_CODE;
      q_item.digits[3] = BLANK_CODE;
    end else begin
      q_item.digits[0] = hi_pair[2*CODE_W-1:CODE_W];
      q_item.digits[1] = hi_pair[CODE_W-1:0];
      q_item.digits[2] = lo_pair[2*CODE_W-1:CODE_W];
      q_item.digits[3] = lo_pair[CODE_W-1:0];
    end
  end

  assign q_push = s3_v_r && adv;

  // whole pipe holds while the queue is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

endmodule

// File: sv/cmdc_queue.sv
`timescale 1ns / 1ps

module cmdc_queue import cmdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cmdc_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output cmdc_item_t head_item
);

  cmdc_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    count_r, count_nxt;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue occupancy out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue occupancy did not follow push");

endmodule

// File: sv/cmdc_back.sv
`timescale 1ns / 1ps

module cmdc_back import cmdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  cmdc_item_t             head_item,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DIGIT_IDX_W-1:0] out_digit_index,
  output logic [BYTE_W-1:0]      out_digit_strobe,
  output logic [BYTE_W-1:0]      out_segments,
  output logic                   out_charge_on,
  output logic                   out_is_tick
);

  logic [CODE_W-1:0]      digit_store_r [DIGIT_COUNT];
  logic                   out_valid_r;
  logic [DIGIT_IDX_W-1:0] idx_r, idx_nxt;
  logic [BYTE_W-1:0]      strobe_r, strobe_nxt;
  logic [BYTE_W-1:0]      segs_r, segs_nxt;
  logic                   chg_r, chg_nxt;
  logic                   tick_r, tick_nxt;

  assign pop = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (head_item.is_tick) begin
      idx_nxt    = head_item.pos;
      strobe_nxt = strobe_of(head_item.pos);
      segs_nxt   = font_of(digit_store_r[head_item.pos]);
      chg_nxt    = head_item.charge_on;
      tick_nxt   = 1'b1;
    end else begin
      idx_nxt    = '0;
      strobe_nxt = NO_STROBE;
      segs_nxt   = NO_SEGS;
      chg_nxt    = 1'b0;
      tick_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_store_r[i] <= '0;
      end
    end else if (pop && !head_item.is_tick) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_store_r[i] <= head_item.digits[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      idx_r    <= idx_nxt;
      strobe_r <= strobe_nxt;
      segs_r   <= segs_nxt;
      chg_r    <= chg_nxt;
      tick_r   <= tick_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_index  = idx_r;
  assign out_digit_strobe = strobe_r;
  assign out_segments     = segs_r;
  assign out_charge_on    = chg_r;
  assign out_is_tick      = tick_r;

  a_meas_no_charge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !tick_r) |-> (!chg_r && strobe_r == NO_STROBE))
    else $error("measurement result drives a digit or charge");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(segs_r) && $stable(idx_r)))
    else $error("result changed while stalled");

  a_store_only_meas: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_item.is_tick) |=> $stable(digit_store_r[0]))
    else $error("digit store changed without a measurement");

endmodule

// File: sv/capacitance_meter_display_controller.sv
// Four-digit display controller of an RC charge-time capacitance meter.
// Input channel (in_valid / in_stall): in_kind 0 is a display tick, in_kind 1
// a finished measurement carrying in_charge_count. Every transaction gives
// exactly one result on the output channel (out_valid / out_stall).
// A tick result carries the digit position, its active-low strobe byte, the
// segment font of the stored digit and the charge output; a measurement
// result carries strobe 0xff, segments 0, charge off and out_is_tick 0.
// Measurements update the stored digits, seen by every later tick.
// Configuration (cfg_we / cfg_index / cfg_wdata) is to be written by the user
// while idle; the block does not enforce it. Index 0 sample period, 1 count
// offset, 2 full scale. A transaction passes three front pipeline stages,
// the queue write and the output register. One transaction is taken per
// cycle while in_stall is low. When the receiver stalls, the output register
// holds, the queue fills, then in_stall rises and the front pipeline holds.
// Reset (rst_n low, synchronous) restores the register defaults 48, 3 and
// 2000, empties the pipeline and queue and clears the digits to 0000.
`timescale 1ns / 1ps

module capacitance_meter_display_controller import cmdc_pkg::*; #(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_kind,
  input  logic [RAW_W-1:0]       in_charge_count,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DIGIT_IDX_W-1:0] out_digit_index,
  output logic [BYTE_W-1:0]      out_digit_strobe,
  output logic [BYTE_W-1:0]      out_segments,
  output logic                   out_charge_on,
  output logic                   out_is_tick
);

  logic       q_full, q_push, q_pop, q_head_valid;
  cmdc_item_t q_item, q_head;

  cmdc_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_charge_count (in_charge_count),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_item          (q_item)
  );

  cmdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head)
  );

  cmdc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_item        (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digit_index  (out_digit_index),
    .out_digit_strobe (out_digit_strobe),
    .out_segments     (out_segments),
    .out_charge_on    (out_charge_on),
    .out_is_tick      (out_is_tick)
  );

endmodule
